// ----- sv/sblf_pkg.sv -----
`timescale 1ns / 1ps

package sblf_pkg;

  localparam int PIX_W          = 8;
  localparam int CHANNELS       = 4;
  localparam int WS_W           = 19;   // tent-weighted sum per channel
  localparam int HALF_W         = 14;   // front / back half sums
  localparam int RADIUS_W       = 6;
  localparam int MAX_RADIUS_DEF = 32;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd16;

  // register index (paddr / 4)
  localparam logic [APB_AW-3:0] REG_BLUR_RADIUS = '0;

  // one RGBA pixel, red in lane 0
  typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

endpackage

// ----- sv/sblf_ring.sv -----
`timescale 1ns / 1ps

// Pixel history: one write port, two registered read ports, one valid bit
// per entry so a clear takes effect at once.
module sblf_ring import sblf_pkg::*; #(
  parameter int DEPTH = 2 * MAX_RADIUS_DEF + 1,
  parameter int AW    = $clog2(2 * MAX_RADIUS_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pixel_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output pixel_t        rdata_a,
  output pixel_t        rdata_b
);

  pixel_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  pixel_t           rd_a_r, rd_b_r;
  logic             va_r, vb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (clear) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        va_r <= !clear && vld_r[raddr_a];
        vb_r <= !clear && vld_r[raddr_b];
      end
    end
  end

  // entries never written since the last clear read as black
  assign rdata_a = va_r ? rd_a_r : '0;
  assign rdata_b = vb_r ? rd_b_r : '0;

endmodule

// ----- sv/sblf_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, four channels side by side, one quotient bit per cycle.
// Caller guarantees num < 2^PIX_W * den, so PIX_W steps give the quotient.
module sblf_div import sblf_pkg::*; #(
  parameter int NUM_W = WS_W + 1,
  parameter int DEN_W = 2 * $clog2(MAX_RADIUS_DEF + 2)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [CHANNELS-1:0][NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]                   den,
  output logic                               busy,
  output logic                               done,
  output pixel_t                             quot
);

  localparam int CMP_W = (NUM_W > DEN_W + PIX_W - 1) ? NUM_W : DEN_W + PIX_W - 1;
  localparam int CNT_W = $clog2(PIX_W);

  logic                             busy_r, done_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [CHANNELS-1:0][CMP_W-1:0]   rem_r, rem_nxt;
  logic [CMP_W-1:0]                 dsh_r;
  pixel_t                           q_r;
  logic [CHANNELS-1:0]              qbit;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      qbit[c]    = (rem_r[c] >= dsh_r);
      rem_nxt[c] = qbit[c] ? rem_r[c] - dsh_r : rem_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PIX_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rem_r[c] <= CMP_W'(num[c]);
      end
      dsh_r <= CMP_W'(den) << (PIX_W - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      for (int c = 0; c < CHANNELS; c++) begin
        q_r[c] <= {q_r[c][PIX_W-2:0], qbit[c]};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- sv/stack_blur_line_filter.sv -----
`timescale 1ns / 1ps
// A new item is accepted only after the previous result has been loaded into out_tdata;
// that load waits for the 8-step shared divider and for room in the output register.
// A new item is taken while the previous result still waits in out_tdata.
// Reset (synchronous, rst_n low): window empty, sums zero, radius 16.
// A radius write clears the window and sums like a line start.

module stack_blur_line_filter import sblf_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic [0:0]        in_tuser,   // line_start
  // blurred pixel output
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // red_out, green_out, blue_out, alpha_out
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ring holds the newest 2*MAX_RADIUS+1 pixels
  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CW    = ((RW > RADIUS_W) ? RW : RADIUS_W) + 1;
  localparam int DW    = 2 * $clog2(MAX_RADIUS + 2);      // (r+1)^2
  localparam int NUM_W = ((WS_W > DW) ? WS_W : DW) + 1;   // sum + divisor/2

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WAIT} st_t;

  st_t                               st_r;
  logic                              acc, line_start, clr, cfg_wr, out_load;
  logic [RADIUS_W-1:0]               radius_r;
  logic [RW-1:0]                     r_eff;
  logic [RW:0]                       rp1;
  logic [DW-1:0]                     divisor;
  logic [AW-1:0]                     newest_r, pos_eff, pos_next;
  logic [AW-1:0]                     mid_addr, old_addr;
  pixel_t                            px_in, px_r, mid_px, old_px;
  logic [CHANNELS-1:0][WS_W-1:0]     ws_r;
  logic [CHANNELS-1:0][HALF_W-1:0]   front_r, back_r;
  logic [CHANNELS-1:0][NUM_W-1:0]    num;
  logic                              div_busy, div_done;
  pixel_t                            quot;
  logic                              out_tvalid_r;
  pixel_t                            out_data_r;

  // slot of the pixel 'age' steps older than the newest one
  function automatic logic [AW-1:0] age_slot(input logic [AW-1:0] pos,
                                             input logic [AW-1:0] age);
    logic [AW:0] t;
    t = {1'b0, pos} + (AW+1)'(DEPTH) - {1'b0, age};
    if (t >= (AW+1)'(DEPTH)) begin
      t = t - (AW+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign px_in      = in_tdata;
  assign line_start = in_tuser[0];
  assign acc        = in_tvalid && in_tready;
  assign in_tready  = (st_r == ST_IDLE);

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[APB_AW-1:2] == REG_BLUR_RADIUS);
  assign cfg_prdata = (cfg_paddr[APB_AW-1:2] == REG_BLUR_RADIUS) ?
                      APB_DW'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr) begin
      radius_r <= cfg_pwdata[RADIUS_W-1:0];
    end
  end

  // radius in effect saturates at MAX_RADIUS
  assign r_eff   = (CW'(radius_r) > CW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_r);
  assign rp1     = (RW+1)'(r_eff) + 1'b1;
  assign divisor = DW'(rp1) * DW'(rp1);

  // ---------------- window ring ----------------
  // Both taps are read on the accept cycle, from the state after any clear.
  // The middle tap (age r-1) is unused at radius zero.
  assign clr      = cfg_wr || (acc && line_start);
  assign pos_eff  = line_start ? '0 : newest_r;
  assign mid_addr = age_slot(pos_eff, (r_eff == '0) ? '0 : AW'(r_eff - 1'b1));
  assign old_addr = age_slot(pos_eff, AW'({r_eff, 1'b0}));
  assign pos_next = (newest_r == AW'(DEPTH - 1)) ? '0 : newest_r + 1'b1;

  sblf_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clr),
    .we      (st_r == ST_READ),
    .waddr   (pos_next),
    .wdata   (px_r),
    .re      (acc),
    .raddr_a (mid_addr),
    .raddr_b (old_addr),
    .rdata_a (mid_px),
    .rdata_b (old_px)
  );

  // ---------------- running sums ----------------
  // Tent update: add the new pixel plus the newest r entries, drop the
  // oldest r+1; the half sums slide by one entry each.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r     <= '0;
      front_r  <= '0;
      back_r   <= '0;
      newest_r <= '0;
    end else if (clr) begin
      ws_r     <= '0;
      front_r  <= '0;
      back_r   <= '0;
      newest_r <= '0;
    end else if (st_r == ST_READ) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ws_r[c]    <= ws_r[c] + WS_W'(px_r[c]) + WS_W'(front_r[c]) - WS_W'(back_r[c]);
        front_r[c] <= front_r[c] + HALF_W'(px_r[c])
                      - HALF_W'((r_eff == '0) ? px_r[c] : mid_px[c]);
        back_r[c]  <= back_r[c] + HALF_W'((r_eff == '0) ? px_r[c] : mid_px[c])
                      - HALF_W'(old_px[c]);
      end
      newest_r <= pos_next;
    end
  end

  // ---------------- rounded average ----------------
  // Output uses the sum before this pixel is folded in; divider starts
  // on the accept cycle with sum + divisor/2.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      num[c] = NUM_W'(line_start ? '0 : ws_r[c]) + NUM_W'(divisor >> 1);
    end
  end

  sblf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc),
    .num   (num),
    .den   (divisor),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // ---------------- control and output register ----------------
  assign out_load = (st_r == ST_WAIT) && div_done && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (acc) begin
            st_r <= ST_READ;
          end
        end
        ST_READ: begin
          st_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_load) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (acc) begin
      px_r <= px_in;
    end
    if (out_load) begin
      out_data_r <= quot;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // the divider is still working while the sums are updated
  a_div_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ) |-> div_busy)
    else $error("divider idle during sum update");

  // a line start leaves the sums zero for the update that follows
  a_line_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && line_start) |=> (ws_r == '0) && (front_r == '0) && (back_r == '0))
    else $error("sums not cleared at line start");

  // a result is only loaded once the divider has finished
  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!div_busy && $past(st_r) != ST_IDLE))
    else $error("result loaded before division finished");

endmodule
